// ----- sv/slt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// slt_pkg: types and constants for the shell line tokenizer.
// No dependencies; used by the channel interfaces and the top level.
package slt_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SQUOTE = 2'd1,
    MODE_DQUOTE = 2'd2,
    MODE_ESCAPE = 2'd3
  } mode_t;

  localparam logic [2:0] KIND_BYTE = 3'd0;
  localparam logic [2:0] KIND_WEND = 3'd1;
  localparam logic [2:0] KIND_OP   = 3'd2;
  localparam logic [2:0] KIND_ERR  = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic [2:0] OP_PIPE  = 3'd0;
  localparam logic [2:0] OP_AMP   = 3'd1;
  localparam logic [2:0] OP_LESS  = 3'd2;
  localparam logic [2:0] OP_GREAT = 3'd3;
  localparam logic [2:0] OP_SEMI  = 3'd4;

  localparam logic ERR_QUOTE  = 1'b0;
  localparam logic ERR_ESCAPE = 1'b1;

  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam int POS_W   = 12;
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_out;
    logic [2:0]       op_kind;
    logic             error_kind;
    logic [POS_W-1:0] error_position;
    logic             last_of_run;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/slt_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// slt_in_if / slt_out_if: valid/ready channels of the shell line tokenizer.
// Depends on slt_pkg for the position width.
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

interface slt_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [7:0]                char_out;
  logic [2:0]                op_kind;
  logic                      error_kind;
  logic [slt_pkg::POS_W-1:0] error_position;
  logic                      last_of_run;

  modport source (output valid, output kind, output char_out, output op_kind,
                  output error_kind, output error_position, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input char_out, input op_kind,
                  input error_kind, input error_position, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/shell_line_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shell_line_tokenizer: streaming shell word tokenizer, one byte per transaction.
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: 1 byte per cycle while out_chan is ready; a byte causing N results (0..3)
// holds the input until its last result is being taken from the 3-entry result buffer.
// Reset (synchronous, rst_n low): normal mode, no pending word, position 0.
// Depends on slt_pkg and slt_chan_if.
module shell_line_tokenizer #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slt_in_if.sink     in_chan,
  slt_out_if.source  out_chan
);

  localparam int PosCapInt = ((MAX_LINE - 1) < 4095) ? (MAX_LINE - 1) : 4095;
  localparam logic [slt_pkg::POS_W-1:0] PosCap = slt_pkg::POS_W'(PosCapInt);

  // lexer state
  slt_pkg::mode_t              mode_r, mode_nxt;
  logic                        wp_r, wp_nxt;
  logic [slt_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [slt_pkg::POS_W-1:0]   qs_r, qs_nxt;
  logic                        disc_r, disc_nxt;

  // result buffer, head at entry 0
  slt_pkg::res_t               res_r   [slt_pkg::MAX_RES];
  slt_pkg::res_t               res_nxt [slt_pkg::MAX_RES];
  logic [1:0]                  cnt_r, cnt_nxt;

  slt_pkg::res_t               slot    [slt_pkg::MAX_RES];
  logic [1:0]                  slot_n;

  logic in_acc, out_acc;

  assign out_chan.valid          = (cnt_r != 2'd0);
  assign out_chan.kind           = res_r[0].kind;
  assign out_chan.char_out       = res_r[0].char_out;
  assign out_chan.op_kind        = res_r[0].op_kind;
  assign out_chan.error_kind     = res_r[0].error_kind;
  assign out_chan.error_position = res_r[0].error_position;
  assign out_chan.last_of_run    = res_r[0].last_of_run;

  assign in_chan.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_chan.ready);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // next state and result generation
  always_comb begin
    logic [7:0]    c;
    logic          eol;
    logic          is_blank, is_op;
    logic [2:0]    opc;
    logic [5:0]    cv;
    slt_pkg::res_t cand [6];
    logic [1:0]    idx;

    c   = in_chan.char_in;
    eol = in_chan.end_of_line;

    is_op = 1'b1;
    opc   = slt_pkg::OP_PIPE;
    case (c)
      slt_pkg::CH_PIPE:  opc = slt_pkg::OP_PIPE;
      slt_pkg::CH_AMP:   opc = slt_pkg::OP_AMP;
      slt_pkg::CH_LESS:  opc = slt_pkg::OP_LESS;
      slt_pkg::CH_GREAT: opc = slt_pkg::OP_GREAT;
      slt_pkg::CH_SEMI:  opc = slt_pkg::OP_SEMI;
      default:           is_op = 1'b0;
    endcase
    is_blank = (c == slt_pkg::CH_SPACE) || (c == slt_pkg::CH_TAB) ||
               (c == slt_pkg::CH_NL);

    mode_nxt = mode_r;
    wp_nxt   = wp_r;
    qs_nxt   = qs_r;
    disc_nxt = disc_r;
    pos_nxt  = pos_r;

    // candidate order: word end, byte, operator, error, word end, line done
    cv = '0;
    for (int i = 0; i < 6; i++) begin
      cand[i] = '0;
    end
    cand[0].kind     = slt_pkg::KIND_WEND;
    cand[1].kind     = slt_pkg::KIND_BYTE;
    cand[1].char_out = c;
    cand[2].kind     = slt_pkg::KIND_OP;
    cand[2].op_kind  = opc;
    cand[3].kind     = slt_pkg::KIND_ERR;
    cand[4].kind     = slt_pkg::KIND_WEND;
    cand[5].kind     = slt_pkg::KIND_DONE;

    if (!disc_r) begin
      case (mode_r)
        slt_pkg::MODE_ESCAPE: begin
          cv[1]    = 1'b1;
          wp_nxt   = 1'b1;
          mode_nxt = slt_pkg::MODE_NORMAL;
        end
        slt_pkg::MODE_SQUOTE, slt_pkg::MODE_DQUOTE: begin
          if (c == ((mode_r == slt_pkg::MODE_SQUOTE) ? slt_pkg::CH_SQUOTE
                                                     : slt_pkg::CH_DQUOTE)) begin
            mode_nxt = slt_pkg::MODE_NORMAL;
          end else begin
            cv[1]  = 1'b1;
            wp_nxt = 1'b1;
          end
        end
        default: begin
          if (is_blank) begin
            cv[0]  = wp_r;
            wp_nxt = 1'b0;
          end else if (is_op) begin
            cv[0]  = wp_r;
            cv[2]  = 1'b1;
            wp_nxt = 1'b0;
          end else if (c == slt_pkg::CH_SQUOTE) begin
            mode_nxt = slt_pkg::MODE_SQUOTE;
            qs_nxt   = pos_r;
          end else if (c == slt_pkg::CH_DQUOTE) begin
            mode_nxt = slt_pkg::MODE_DQUOTE;
            qs_nxt   = pos_r;
          end else if (c == slt_pkg::CH_BSLASH) begin
            mode_nxt = slt_pkg::MODE_ESCAPE;
          end else begin
            cv[1]  = 1'b1;
            wp_nxt = 1'b1;
          end
        end
      endcase
    end

    if (eol) begin
      if (!disc_r) begin
        if (mode_nxt == slt_pkg::MODE_ESCAPE) begin
          cv[3]                  = 1'b1;
          cand[3].error_kind     = slt_pkg::ERR_ESCAPE;
          cand[3].error_position = pos_r;
        end else if (mode_nxt != slt_pkg::MODE_NORMAL) begin
          cv[3]                  = 1'b1;
          cand[3].error_kind     = slt_pkg::ERR_QUOTE;
          cand[3].error_position = qs_nxt;
        end else begin
          cv[4] = wp_nxt;
        end
      end
      cv[5]    = 1'b1;
      mode_nxt = slt_pkg::MODE_NORMAL;
      wp_nxt   = 1'b0;
      disc_nxt = 1'b0;
      pos_nxt  = '0;
    end else if (pos_r < PosCap) begin
      pos_nxt = pos_r + 1'b1;
    end

    // pack the active candidates into the result slots
    idx = 2'd0;
    for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
      slot[k] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      if (cv[i] && (idx < 2'd3)) begin
        slot[idx] = cand[i];
        idx       = idx + 2'd1;
      end
    end
    for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
      slot[k].last_of_run = (idx == 2'(k + 1));
    end
    slot_n = idx;
  end

  // buffer update
  always_comb begin
    for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
      res_nxt[k] = res_r[k];
    end
    cnt_nxt = cnt_r;
    if (in_acc) begin
      for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
        res_nxt[k] = slot[k];
      end
      cnt_nxt = slot_n;
    end else if (out_acc) begin
      for (int k = 0; k < slt_pkg::MAX_RES - 1; k++) begin
        res_nxt[k] = res_r[k + 1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slt_pkg::MODE_NORMAL;
      wp_r   <= 1'b0;
      pos_r  <= '0;
      qs_r   <= '0;
      disc_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        wp_r   <= wp_nxt;
        pos_r  <= pos_nxt;
        qs_r   <= qs_nxt;
        disc_r <= disc_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
      res_r[k] <= res_nxt[k];
    end
  end

`ifndef SYNTHESIS
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> res_r[0].last_of_run)
    else $error("single buffered result not marked last");

  a_not_last_multi: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd2) || (cnt_r == 2'd3)) |-> !res_r[0].last_of_run)
    else $error("head result marked last while more are queued");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.end_of_line) |=>
      ((pos_r == '0) && (mode_r == slt_pkg::MODE_NORMAL) && !wp_r))
    else $error("lexer state not cleared after end of line");

  a_eol_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.end_of_line) |=> (cnt_r != 2'd0))
    else $error("end of line produced no line-done result");
`endif

endmodule
`default_nettype wire
